/* hdl/fcr_pkg.sv */
// Shared types, constants and helpers for the framed command receiver.
package fcr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAGE_W = 3;
    localparam int unsigned TENS_W  = 5;
    localparam int unsigned UNITS_W = 4;

    localparam logic [STAGE_W-1:0] STAGE_MAX = 3'd5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_START_CODE   = 2'd0,
        REG_STOP_CODE    = 2'd1,
        REG_BROADCAST_ID = 2'd2,
        REG_OWN_ID       = 2'd3
    } cfg_reg_e;

    localparam logic [BYTE_W-1:0] START_CODE_RST   = 8'h02;
    localparam logic [BYTE_W-1:0] STOP_CODE_RST    = 8'h03;
    localparam logic [BYTE_W-1:0] BROADCAST_ID_RST = 8'h00;
    localparam logic [BYTE_W-1:0] OWN_ID_RST       = 8'h10;

    // Frame byte positions
    localparam logic [STAGE_W-1:0] STAGE_ADDRESS = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_COMMAND = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_DATA1   = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_DATA2   = 3'd4;

    // Command codes
    localparam logic [BYTE_W-1:0] CMD_SET_PATTERN = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_CLEAR_ALL   = 8'h11;
    localparam logic [BYTE_W-1:0] CMD_SET_BIT     = 8'h12;
    localparam logic [BYTE_W-1:0] CMD_CLEAR_BIT   = 8'h13;
    localparam logic [BYTE_W-1:0] CMD_DECIMAL     = 8'h14;

    // Closed, addressed frame as seen by the executor
    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] data1;
        logic [BYTE_W-1:0] data2;
    } frame_evt_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  command;
        logic [BYTE_W-1:0]  port_high;
        logic [BYTE_W-1:0]  port_low;
        logic [TENS_W-1:0]  digit_three;
        logic [UNITS_W-1:0] digit_two;
        logic [TENS_W-1:0]  digit_one;
        logic [UNITS_W-1:0] digit_zero;
    } fcr_result_t;

    // One-hot byte mask; indexes of eight or more give zero
    function automatic logic [BYTE_W-1:0] bit_mask(input logic [BYTE_W-1:0] idx);
        logic [BYTE_W-1:0] m;
        m = '0;
        if (idx[BYTE_W-1:3] == '0)
        begin
            m[idx[2:0]] = 1'b1;
        end
        return m;
    endfunction

    // Tens of a byte: x * 205 >> 11 is exact for x below 1029
    function automatic logic [TENS_W-1:0] tens_of(input logic [BYTE_W-1:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd205;
        return prod[15:11];
    endfunction

    function automatic logic [UNITS_W-1:0] units_of(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] tens_x10;
        logic [BYTE_W-1:0] rem;
        tens_x10 = 8'(tens_of(x)) * 8'd10;
        rem      = x - tens_x10;
        return rem[UNITS_W-1:0];
    endfunction

endpackage

/* hdl/fcr_byte_if.sv */
// Byte channel into the receiver.
interface fcr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/fcr_result_if.sv */
// Result channel out of the receiver.
interface fcr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] command;
    logic [7:0] port_high_out;
    logic [7:0] port_low_out;
    logic [4:0] digit_three;
    logic [3:0] digit_two;
    logic [4:0] digit_one;
    logic [3:0] digit_zero;

    modport source (output valid, output command, output port_high_out,
                    output port_low_out, output digit_three, output digit_two,
                    output digit_one, output digit_zero, input ready);
    modport sink   (input valid, input command, input port_high_out,
                    input port_low_out, input digit_three, input digit_two,
                    input digit_one, input digit_zero, output ready);
endinterface

/* hdl/fcr_frame.sv */
// Frame assembler: start/stop tracking, stage counter and stored frame bytes.
module fcr_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           start_code,
    input  logic [7:0]           stop_code,
    input  logic [7:0]           broadcast_id,
    input  logic [7:0]           own_id,
    output fcr_pkg::frame_evt_t  evt
);
    import fcr_pkg::*;

    logic               in_frame_reg,  in_frame_next;
    logic [STAGE_W-1:0] stage_reg,     stage_next;
    logic [BYTE_W-1:0]  address_reg,   address_next;
    logic [BYTE_W-1:0]  command_reg,   command_next;
    logic [BYTE_W-1:0]  data1_reg,     data1_next;
    logic [BYTE_W-1:0]  data2_reg,     data2_next;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        stage_next    = stage_reg;
        address_next  = address_reg;
        command_next  = command_reg;
        data1_next    = data1_reg;
        data2_next    = data2_reg;
        evt.hit       = 1'b0;

        // every byte inside a frame, the closing one too, advances the stage up to STAGE_MAX
        if (in_frame_reg)
        begin
            if (stage_reg < STAGE_MAX)
            begin
                stage_next = stage_reg + 3'd1;
            end
            unique case (stage_next)
                STAGE_ADDRESS: address_next = rx_byte;
                STAGE_COMMAND: command_next = rx_byte;
                STAGE_DATA1:   data1_next   = rx_byte;
                STAGE_DATA2:   data2_next   = rx_byte;
                default: ;
            endcase
        end

        priority if (rx_byte == start_code && !in_frame_reg)
        begin
            in_frame_next = 1'b1;
        end
        else if (rx_byte == stop_code && in_frame_reg)
        begin
            in_frame_next = 1'b0;
            stage_next    = '0;
            evt.hit       = (address_next == broadcast_id) || (address_next == own_id);
        end
        else
        begin
        end

        evt.command = command_next;
        evt.data1   = data1_next;
        evt.data2   = data2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            stage_reg    <= '0;
            address_reg  <= '0;
            command_reg  <= '0;
            data1_reg    <= '0;
            data2_reg    <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            stage_reg    <= stage_next;
            address_reg  <= address_next;
            command_reg  <= command_next;
            data1_reg    <= data1_next;
            data2_reg    <= data2_next;
        end
    end

endmodule

/* hdl/fcr_exec.sv */
// Command executor: LED port state and display digits.
module fcr_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  fcr_pkg::frame_evt_t  evt,
    output fcr_pkg::fcr_result_t result
);
    import fcr_pkg::*;

    logic [BYTE_W-1:0]  port_high_reg, port_high_next;
    logic [BYTE_W-1:0]  port_low_reg,  port_low_next;
    logic [TENS_W-1:0]  dig3_reg, dig3_next;
    logic [UNITS_W-1:0] dig2_reg, dig2_next;
    logic [TENS_W-1:0]  dig1_reg, dig1_next;
    logic [UNITS_W-1:0] dig0_reg, dig0_next;
    logic [BYTE_W-1:0]  set_mask;
    logic [BYTE_W-1:0]  keep_mask;

    always_comb
    begin
        set_mask       = bit_mask(evt.data1);
        keep_mask      = ~bit_mask(evt.data2);
        port_high_next = port_high_reg;
        port_low_next  = port_low_reg;
        dig3_next      = dig3_reg;
        dig2_next      = dig2_reg;
        dig1_next      = dig1_reg;
        dig0_next      = dig0_reg;

        unique case (evt.command)
            CMD_SET_PATTERN:
            begin
                port_high_next = {evt.data1[3:0], 4'h0};
                port_low_next  = evt.data1;
            end
            CMD_CLEAR_ALL:
            begin
                port_high_next = '0;
                port_low_next  = '0;
            end
            CMD_SET_BIT:
            begin
                port_high_next = port_high_reg | {set_mask[3:0], 4'h0};
                port_low_next  = port_low_reg | set_mask;
            end
            CMD_CLEAR_BIT:
            begin
                // shifted mask always clears the low nibble of the high port
                port_high_next = port_high_reg & {keep_mask[3:0], 4'h0};
                port_low_next  = port_low_reg & keep_mask;
            end
            CMD_DECIMAL:
            begin
                dig3_next = tens_of(evt.data1);
                dig2_next = units_of(evt.data1);
                dig1_next = tens_of(evt.data2);
                dig0_next = units_of(evt.data2);
            end
            default: ;
        endcase

        result.command     = evt.command;
        result.port_high   = port_high_next;
        result.port_low    = port_low_next;
        result.digit_three = dig3_next;
        result.digit_two   = dig2_next;
        result.digit_one   = dig1_next;
        result.digit_zero  = dig0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_high_reg <= '0;
            port_low_reg  <= '0;
            dig3_reg      <= '0;
            dig2_reg      <= '0;
            dig1_reg      <= '0;
            dig0_reg      <= '0;
        end
        else if (step && evt.hit)
        begin
            port_high_reg <= port_high_next;
            port_low_reg  <= port_low_next;
            dig3_reg      <= dig3_next;
            dig2_reg      <= dig2_next;
            dig1_reg      <= dig1_next;
            dig0_reg      <= dig0_next;
        end
    end

endmodule

/* hdl/framed_command_receiver.sv */
// Framed command receiver: byte-stream framing, address match and command execution.
//
// Usage notes
//   byte_ch   : received bytes, one per transfer (valid/ready).
//   result_ch : one transfer per closed frame whose address matches own_id or
//               broadcast_id; carries the command and the port/digit state after it.
//   wr_en/reg_index/wr_data : register writes (start code, stop code,
//               broadcast id, own id), taken at any edge with wr_en high; write
//               only while no byte is in flight.
//   Path      : a taken byte waits in the input register until the processing
//               stage advances; a result it causes is written into the result
//               register and offered on result_ch until taken.
//   Throughput: one byte per cycle while no result stalls. An input register
//               feeds the frame and command logic, which writes a result register.
//   Stall     : while a result waits untaken the processing stage holds; one
//               more byte may land in the input register, then byte_ch.ready
//               drops until result_ch takes the waiting result.
//   Reset     : rst_n (asynchronous, active low) clears frame state, ports,
//               digits, both pipeline valid flags and restores register defaults.
module framed_command_receiver (
    input  logic                clk,
    input  logic                rst_n,
    fcr_byte_if.sink            byte_ch,
    fcr_result_if.source        result_ch,
    input  logic                wr_en,
    input  logic [1:0]          reg_index,
    input  logic [7:0]          wr_data
);
    import fcr_pkg::*;

    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] stop_code_reg;
    logic [BYTE_W-1:0] broadcast_id_reg;
    logic [BYTE_W-1:0] own_id_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              res_valid_reg;
    fcr_result_t       res_reg;

    logic              advance;
    logic              step;
    frame_evt_t        evt;
    fcr_result_t       result;
    cfg_reg_e          wr_sel;

    // processing stage moves when the result slot is empty or being drained
    assign advance       = !res_valid_reg || result_ch.ready;
    assign step          = in_valid_reg && advance;
    assign byte_ch.ready = !in_valid_reg || advance;
    assign wr_sel        = cfg_reg_e'(reg_index);

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg   <= START_CODE_RST;
            stop_code_reg    <= STOP_CODE_RST;
            broadcast_id_reg <= BROADCAST_ID_RST;
            own_id_reg       <= OWN_ID_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_sel)
                REG_START_CODE:   start_code_reg   <= wr_data;
                REG_STOP_CODE:    stop_code_reg    <= wr_data;
                REG_BROADCAST_ID: broadcast_id_reg <= wr_data;
                REG_OWN_ID:       own_id_reg       <= wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.rx_byte;
        end
    end

    fcr_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .start_code   (start_code_reg),
        .stop_code    (stop_code_reg),
        .broadcast_id (broadcast_id_reg),
        .own_id       (own_id_reg),
        .evt          (evt)
    );

    fcr_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .evt    (evt),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= step && evt.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && evt.hit)
        begin
            res_reg <= result;
        end
    end

    assign result_ch.valid         = res_valid_reg;
    assign result_ch.command       = res_reg.command;
    assign result_ch.port_high_out = res_reg.port_high;
    assign result_ch.port_low_out  = res_reg.port_low;
    assign result_ch.digit_three   = res_reg.digit_three;
    assign result_ch.digit_two     = res_reg.digit_two;
    assign result_ch.digit_one     = res_reg.digit_one;
    assign result_ch.digit_zero    = res_reg.digit_zero;

endmodule

/* hdl/fcr_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module fcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] command,
    input logic [7:0] port_high_out,
    input logic [7:0] port_low_out,
    input logic [4:0] digit_three,
    input logic [3:0] digit_two,
    input logic [4:0] digit_one,
    input logic [3:0] digit_zero
);
    import fcr_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(command) && $stable(port_high_out)
                            && $stable(port_low_out) && $stable(digit_two))
        else $error("result changed while stalled");

    a_units: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> digit_two <= 4'd9 && digit_zero <= 4'd9
                  && digit_three <= 5'd25 && digit_one <= 5'd25)
        else $error("display digit out of decimal range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        valid && command == CMD_CLEAR_ALL |-> port_high_out == 8'h00
                                             && port_low_out == 8'h00)
        else $error("clear command left LEDs set");

    a_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        valid && command == CMD_SET_PATTERN
            |-> port_high_out == {port_low_out[3:0], 4'h0})
        else $error("pattern ports disagree");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result_ch.valid),
    .ready         (result_ch.ready),
    .command       (result_ch.command),
    .port_high_out (result_ch.port_high_out),
    .port_low_out  (result_ch.port_low_out),
    .digit_three   (result_ch.digit_three),
    .digit_two     (result_ch.digit_two),
    .digit_one     (result_ch.digit_one),
    .digit_zero    (result_ch.digit_zero)
);
